// ===== rtl/ope_pkg.sv =====
// types and constants shared by the ogg page frame extractor modules
// no dependencies
`default_nettype none

package ope_pkg;

    // capture pattern and fixed header layout
    localparam int unsigned HDR_LEN      = 27;
    localparam int unsigned MAX_SEGMENTS = 255;
    localparam int unsigned SEG_AW       = 8;
    localparam int unsigned Q_DEPTH      = 4;
    localparam int unsigned Q_AW         = 2;

    localparam logic [7:0] CAPTURE_PATTERN [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

    // result kind codes
    localparam logic KIND_FRAME       = 1'b0;
    localparam logic KIND_BAD_PATTERN = 1'b1;

    // one item from the front parser to the frame walker
    typedef struct packed {
        logic        kind;
        logic [15:0] offset;
        logic [7:0]  count;
    } ope_event_t;

    // lacing table write port
    typedef struct packed {
        logic              en;
        logic [SEG_AW-1:0] addr;
        logic [7:0]        data;
    } ope_wr_t;

endpackage

`default_nettype wire

// ===== rtl/ope_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ope_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ope_fifo.sv =====
// short event queue between the page parser and the frame walker
// depends on ope_pkg
`default_nettype none

module ope_fifo
    import ope_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  ope_event_t      din,
    input  wire logic       pop,
    output ope_event_t      dout,
    output logic            full,
    output logic            empty
);

    ope_event_t      store [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("event queue count past depth");

endmodule

`default_nettype wire

// ===== rtl/ope_front.sv =====
// page parser: walks headers and lacing tables, fills the lacing ram,
// queues payload and status items; depends on ope_pkg
`default_nettype none

module ope_front
    import ope_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic [15:0] buffer_length,
    input  wire logic        q_full,
    input  wire logic        q_empty,
    output logic             full,
    output logic             ev_push,
    output ope_event_t       ev,
    output ope_wr_t          wr,
    output logic             page_start
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_TABLE   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [1:0]  phase;
        logic [4:0]  hcnt;
        logic        pat_ok;
        logic        seq_small;
        logic [7:0]  seg;
        logic [7:0]  trc;
        logic [7:0]  nzc;
        logic [16:0] ptot;
        logic [16:0] pleft;
        logic        skip;
    } page_t;

    localparam page_t PAGE_RESET = '{
        phase:     PH_HEADER,
        hcnt:      5'd0,
        pat_ok:    1'b1,
        seq_small: 1'b1,
        seg:       8'd0,
        trc:       8'd0,
        nzc:       8'd0,
        ptot:      17'd0,
        pleft:     17'd0,
        skip:      1'b0
    };

    page_t       pg_reg, pg_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic        halted_reg, halted_next;
    logic        acc;
    logic [15:0] pos_inc;
    logic [17:0] end_sum;

    // hold off the lacing table until the walker has used the old one
    assign full = q_full || (pg_reg.phase == PH_TABLE && !q_empty);
    assign acc  = push && !full;

    always_comb
    begin
        pg_next     = pg_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        halted_next = halted_reg;
        ev_push     = 1'b0;
        ev          = '0;
        wr          = '0;
        page_start  = 1'b0;
        pos_inc     = '0;
        end_sum     = '0;
        if (acc)
        begin
            if (first_byte)
            begin
                pg_next     = PAGE_RESET;
                total_next  = buffer_length;
                pos_next    = '0;
                halted_next = 1'b0;
            end
            if (!halted_next)
            begin
                if (pos_next >= total_next)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    pos_inc = pos_next + 16'd1;
                    unique case (pg_next.phase)
                        PH_HEADER:
                        begin
                            if (pg_next.hcnt == 5'd0 &&
                                ({1'b0, pos_next} + 17'(HDR_LEN)) > {1'b0, total_next})
                            begin
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                if (pg_next.hcnt < 5'd4 &&
                                    data_byte != CAPTURE_PATTERN[pg_next.hcnt[1:0]])
                                begin
                                    pg_next.pat_ok = 1'b0;
                                end
                                if (pg_next.hcnt == 5'd18 && data_byte > 8'd1)
                                begin
                                    pg_next.seq_small = 1'b0;
                                end
                                if (pg_next.hcnt >= 5'd19 && pg_next.hcnt <= 5'd21 &&
                                    data_byte != 8'd0)
                                begin
                                    pg_next.seq_small = 1'b0;
                                end
                                if (pg_next.hcnt != 5'(HDR_LEN - 1))
                                begin
                                    pg_next.hcnt = pg_next.hcnt + 5'd1;
                                    pos_next     = pos_inc;
                                end
                                else if (!pg_next.pat_ok)
                                begin
                                    ev_push     = 1'b1;
                                    ev.kind     = KIND_BAD_PATTERN;
                                    ev.offset   = pos_next - 16'(HDR_LEN - 1);
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    pg_next.seg = data_byte;
                                    if (({1'b0, pos_inc} + {9'd0, data_byte}) >
                                        {1'b0, total_next})
                                    begin
                                        halted_next = 1'b1;
                                    end
                                    else if (data_byte == 8'd0)
                                    begin
                                        pg_next  = PAGE_RESET;
                                        pos_next = pos_inc;
                                    end
                                    else
                                    begin
                                        pg_next.phase = PH_TABLE;
                                        pos_next      = pos_inc;
                                    end
                                end
                            end
                        end
                        PH_TABLE:
                        begin
                            page_start = (pg_next.trc == 8'd0);
                            if (data_byte != 8'd0)
                            begin
                                wr.en       = 1'b1;
                                wr.addr     = pg_next.nzc;
                                wr.data     = data_byte;
                                pg_next.nzc = pg_next.nzc + 8'd1;
                            end
                            pg_next.ptot = pg_next.ptot + {9'd0, data_byte};
                            pg_next.trc  = pg_next.trc + 8'd1;
                            pos_next     = pos_inc;
                            if (pg_next.trc >= pg_next.seg)
                            begin
                                end_sum = {2'b0, pos_inc} + {1'b0, pg_next.ptot};
                                if (end_sum > {2'b0, total_next})
                                begin
                                    halted_next = 1'b1;
                                end
                                else if (pg_next.ptot == 17'd0)
                                begin
                                    pg_next = PAGE_RESET;
                                end
                                else
                                begin
                                    pg_next.phase = PH_PAYLOAD;
                                    pg_next.pleft = pg_next.ptot;
                                    // sequence 0 or 1 pages carry no frames
                                    pg_next.skip  = pg_next.seq_small;
                                end
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            if (!pg_next.skip)
                            begin
                                ev_push   = 1'b1;
                                ev.kind   = KIND_FRAME;
                                ev.offset = pos_next;
                                ev.count  = pg_next.nzc;
                            end
                            pg_next.pleft = pg_next.pleft - 17'd1;
                            if (pg_next.pleft == 17'd0)
                            begin
                                pg_next = PAGE_RESET;
                            end
                            pos_next = pos_inc;
                        end
                        default:
                        begin
                            pg_next = PAGE_RESET;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pg_reg     <= PAGE_RESET;
            pos_reg    <= '0;
            total_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            pg_reg     <= pg_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            halted_reg <= halted_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ev_push |-> !q_full)
        else $error("item pushed into a full event queue");

endmodule

`default_nettype wire

// ===== rtl/ope_back.sv =====
// frame walker: turns queued payload items into frame results using the
// lacing ram, and holds the result register; depends on ope_pkg
`default_nettype none

module ope_back
    import ope_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  ope_event_t             q_dout,
    output logic                   q_pop,
    input  wire logic              page_start,
    output logic [SEG_AW-1:0]      rd_addr,
    input  wire logic [7:0]        rd_data,
    input  wire logic              pop,
    output logic                   empty,
    output logic [15:0]            frame_offset,
    output logic [7:0]             frame_length,
    output logic                   result_kind
);

    logic        out_valid_reg;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  length_reg, length_next;
    logic        kind_reg, kind_next;
    logic [7:0]  fidx_reg, fidx_next;
    logic [7:0]  left_reg, left_next;
    logic        out_free;
    logic        load;
    logic [7:0]  len;

    assign out_free = !out_valid_reg || pop;
    assign q_pop    = !q_empty && out_free;
    // the ram always reads the entry the next frame will need
    assign rd_addr  = fidx_next;

    always_comb
    begin
        fidx_next   = fidx_reg;
        left_next   = left_reg;
        load        = 1'b0;
        offset_next = offset_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        len         = (fidx_reg < q_dout.count) ? rd_data : 8'd0;
        if (page_start)
        begin
            fidx_next = '0;
            left_next = '0;
        end
        else if (q_pop)
        begin
            if (q_dout.kind == KIND_BAD_PATTERN)
            begin
                load        = 1'b1;
                offset_next = q_dout.offset;
                length_next = 8'd0;
                kind_next   = KIND_BAD_PATTERN;
            end
            else if (left_reg == 8'd0)
            begin
                if (len != 8'd0)
                begin
                    load        = 1'b1;
                    offset_next = q_dout.offset;
                    length_next = len;
                    kind_next   = KIND_FRAME;
                    left_next   = len - 8'd1;
                    fidx_next   = fidx_reg + 8'd1;
                end
            end
            else
            begin
                left_next = left_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        length_reg <= length_next;
        kind_reg   <= kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fidx_reg      <= '0;
            left_reg      <= '0;
        end
        else
        begin
            fidx_reg <= fidx_next;
            left_reg <= left_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign frame_offset = offset_reg;
    assign frame_length = length_reg;
    assign result_kind  = kind_reg;

    a_page_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        page_start |-> q_empty)
        else $error("lacing table restarted while items still queued");

    a_frame_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_FRAME) |-> (length_reg != 8'd0))
        else $error("frame result with zero length");

endmodule

`default_nettype wire

// ===== rtl/ogg_page_frame_extractor.sv =====
// top level of the ogg page frame extractor: parser, event queue,
// lacing ram and frame walker; depends on ope_pkg and all ope_* modules
`default_nettype none

// usage
// input channel: one buffer byte per item on data_byte, taken when push is
//   high and full is low; first_byte marks the first byte of a buffer and
//   buffer_length is sampled with it
// result channel: frame_offset, frame_length and result_kind hold the
//   oldest result while empty is low; pop takes it
// result_kind 0 is a frame (offset in the buffer, length in bytes),
//   result_kind 1 is a bad capture pattern with the page's start offset,
//   after which parsing stops until the next first byte
// throughput: one byte per cycle; the parser takes a byte every cycle
//   while the four item event queue has room
// the first lacing table byte of a page waits until the frame walker has
//   drained the queue, since the lacing ram holds a single page
// a frame result passes from the event queue into the result register
// when pop stays low the result register holds, the queue fills and full
//   rises; nothing is dropped
// reset clears the parse state; bytes before any first byte are ignored
// the lacing ram needs no clearing: only entries written for the current
//   page are ever read

module ogg_page_frame_extractor
    import ope_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic [15:0] buffer_length,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      frame_offset,
    output logic [7:0]       frame_length,
    output logic             result_kind
);

    ope_event_t        ev;
    ope_event_t        q_dout;
    ope_wr_t           wr;
    logic              ev_push;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              page_start;
    logic [SEG_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    // front: header and lacing table parse
    ope_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .buffer_length (buffer_length),
        .q_full        (q_full),
        .q_empty       (q_empty),
        .full          (full),
        .ev_push       (ev_push),
        .ev            (ev),
        .wr            (wr),
        .page_start    (page_start)
    );

    // nonzero lacing values of the current page
    ope_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SEGMENTS)
    ) u_lacing_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // decouples parsing from result delivery
    ope_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ev_push),
        .din   (ev),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: frame walk and result register
    ope_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_dout       (q_dout),
        .q_pop        (q_pop),
        .page_start   (page_start),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .pop          (pop),
        .empty        (empty),
        .frame_offset (frame_offset),
        .frame_length (frame_length),
        .result_kind  (result_kind)
    );

endmodule

`default_nettype wire
